>>> src/cbm_pkg.sv
package cbm_pkg;

    // Field widths
    localparam int AddrW    = 16;
    localparam int DataW    = 8;
    localparam int MapW     = 21;
    localparam int RomBankW = 7;
    localparam int RamBankW = 2;
    localparam int CfgIdxW  = 2;
    localparam int CfgDataW = 8;

    // Beat widths; the data widths are padded to whole bytes
    localparam int STDataW = 24;
    localparam int MTDataW = 24;
    localparam int MTUserW = 4;

    // Result regions
    typedef enum logic [2:0] {
        REGION_ROM_FIXED = 3'd0,
        REGION_ROM_BANK  = 3'd1,
        REGION_RAM       = 3'd2,
        REGION_RAM_OFF   = 3'd3,
        REGION_MAPPER    = 3'd4,
        REGION_INTERNAL  = 3'd5
    } region_t;

    // Mapper kinds
    localparam logic [1:0] KIND_NONE = 2'd0;
    localparam logic [1:0] KIND_MBC1 = 2'd1;
    localparam logic [1:0] KIND_MBC3 = 2'd2;

    // RAM size codes
    localparam logic [1:0] RAM_2K  = 2'd0;
    localparam logic [1:0] RAM_8K  = 2'd1;
    localparam logic [1:0] RAM_32K = 2'd2;

    // Configuration register indexes
    localparam logic [CfgIdxW-1:0] CFG_MAPPER_KIND   = 2'd0;
    localparam logic [CfgIdxW-1:0] CFG_ROM_BANK_MASK = 2'd1;
    localparam logic [CfgIdxW-1:0] CFG_RAM_SIZE_CODE = 2'd2;

    // Bus access kinds
    localparam logic REQ_READ  = 1'b0;
    localparam logic REQ_WRITE = 1'b1;

    // Address windows, decoded on address bits 15:13
    localparam logic [2:0] WIN_RAM_ENABLE = 3'd0;
    localparam logic [2:0] WIN_ROM_LOW    = 3'd1;
    localparam logic [2:0] WIN_BANK_HIGH  = 3'd2;
    localparam logic [2:0] WIN_MODE       = 3'd3;
    localparam logic [2:0] WIN_CART_RAM   = 3'd5;

    localparam logic [3:0] RAM_ENABLE_KEY = 4'hA;

endpackage

>>> src/cartridge_bank_mapper.sv
// Bank controller for MBC1 / MBC3 style cartridges.
// The result beat is registered and appears in the cycle after its input beat is accepted.
// Throughput: one access per cycle while m_tready is high; the output register
// frees itself in the cycle its beat is taken, so the input stays ready.
// Reset (aresetn low, synchronous): rom_bank 1, ram_bank 0, RAM disabled,
// ROM banking mode, no mapper, mask 1, 8KB RAM; output register empty.
module cartridge_bank_mapper (
    input  logic                          aclk,
    input  logic                          aresetn,
    // configuration write channel
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [cbm_pkg::CfgIdxW-1:0]   cfg_index,
    input  logic [cbm_pkg::CfgDataW-1:0]  cfg_data,
    // input channel
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [cbm_pkg::STDataW-1:0]   s_tdata,  // [15:0] address, [23:16] write_data
    input  logic                          s_tuser,  // [0] req_type
    // result channel
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [cbm_pkg::MTDataW-1:0]   m_tdata,  // [20:0] mapped_address, [23:21] zero
    output logic [cbm_pkg::MTUserW-1:0]   m_tuser   // [2:0] region, [3] open_bus
);
    import cbm_pkg::*;

    // Configuration registers
    logic [1:0]          mapper_kind_reg;
    logic [RomBankW-1:0] rom_bank_mask_reg;
    logic [1:0]          ram_size_code_reg;

    // Banking state
    logic [RomBankW-1:0] rom_bank_reg,    rom_bank_next;
    logic [RamBankW-1:0] ram_bank_reg,    ram_bank_next;
    logic                ram_enabled_reg, ram_enabled_next;
    logic                rom_mode_reg,    rom_mode_next;

    // Output register
    logic                m_tvalid_reg;
    region_t             region_reg,      region_next;
    logic [MapW-1:0]     mapped_reg,      mapped_next;
    logic                open_bus_reg,    open_bus_next;

    logic                s_fire;
    logic                req_type;
    logic [AddrW-1:0]    address;
    logic [DataW-1:0]    write_data;
    logic [2:0]          window;
    logic                is_mbc1;
    logic                is_mbc3;
    logic [RomBankW-1:0] low_bank;
    logic [RomBankW-1:0] high_bank;
    logic [14:0]         ram_offset;

    assign cfg_ready  = 1'b1;
    assign s_tready   = !m_tvalid_reg || m_tready;
    assign s_fire     = s_tvalid && s_tready;
    assign req_type   = s_tuser;
    assign address    = s_tdata[15:0];
    assign write_data = s_tdata[23:16];
    assign window     = address[15:13];
    assign is_mbc1    = (mapper_kind_reg == KIND_MBC1);
    assign is_mbc3    = (mapper_kind_reg == KIND_MBC3);

    // Take configuration writes; unknown indexes are dropped
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mapper_kind_reg   <= KIND_NONE;
            rom_bank_mask_reg <= RomBankW'(1);
            ram_size_code_reg <= RAM_8K;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                CFG_MAPPER_KIND:   mapper_kind_reg   <= cfg_data[1:0];
                CFG_ROM_BANK_MASK: rom_bank_mask_reg <= cfg_data[RomBankW-1:0];
                CFG_RAM_SIZE_CODE: ram_size_code_reg <= cfg_data[1:0];
                default: ;
            endcase
        end
    end

    // Candidate bank values for the low and high bank writes
    always_comb begin
        if (is_mbc1) begin
            low_bank = (rom_bank_reg & 7'h60) | (write_data[RomBankW-1:0] & rom_bank_mask_reg);
            if (write_data == '0) begin
                low_bank = RomBankW'(1);
            end
        end else begin
            low_bank = write_data[RomBankW-1:0];
            if (low_bank == '0) begin
                low_bank = RomBankW'(1);
            end
        end
        high_bank = {write_data[1:0], rom_bank_reg[4:0]};
        if (high_bank == '0) begin
            high_bank = RomBankW'(1);
        end
    end

    // Update the banking registers on a register write
    always_comb begin
        rom_bank_next    = rom_bank_reg;
        ram_bank_next    = ram_bank_reg;
        ram_enabled_next = ram_enabled_reg;
        rom_mode_next    = rom_mode_reg;
        if (s_fire && req_type == REQ_WRITE && !address[15] && (is_mbc1 || is_mbc3)) begin
            case (window)
                WIN_RAM_ENABLE: ram_enabled_next = (write_data[3:0] == RAM_ENABLE_KEY);
                WIN_ROM_LOW:    rom_bank_next    = low_bank;
                WIN_BANK_HIGH: begin
                    if (rom_mode_reg) begin
                        if (is_mbc1) begin
                            rom_bank_next = high_bank;
                        end
                    end else begin
                        ram_bank_next = write_data[RamBankW-1:0];
                    end
                end
                WIN_MODE: begin
                    rom_mode_next = !write_data[0];
                    if (!write_data[0]) begin
                        ram_bank_next = '0;
                    end
                end
                default: ;
            endcase
        end
    end

    // RAM byte offset by cartridge RAM size and banking mode
    always_comb begin
        case (ram_size_code_reg)
            RAM_2K:  ram_offset = {4'b0, address[10:0]};
            RAM_32K: ram_offset = rom_mode_reg ? {2'b0, address[12:0]}
                                               : {ram_bank_reg, address[12:0]};
            default: ram_offset = {2'b0, address[12:0]};
        endcase
    end

    // Classify the access and form the mapped address
    always_comb begin
        mapped_next   = {5'b0, address};
        open_bus_next = 1'b0;
        if (!address[15] && req_type == REQ_WRITE) begin
            region_next = REGION_MAPPER;
        end else if (address[15:14] == 2'b00) begin
            region_next = REGION_ROM_FIXED;
        end else if (address[15:14] == 2'b01) begin
            region_next = REGION_ROM_BANK;
            mapped_next = {rom_bank_reg, address[13:0]};
        end else if (window == WIN_CART_RAM) begin
            if (ram_enabled_reg) begin
                region_next = REGION_RAM;
                mapped_next = {6'b0, ram_offset};
            end else begin
                region_next   = REGION_RAM_OFF;
                open_bus_next = (req_type == REQ_READ);
            end
        end else begin
            region_next = REGION_INTERNAL;
        end
    end

    // Hold the banking state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rom_bank_reg    <= RomBankW'(1);
            ram_bank_reg    <= '0;
            ram_enabled_reg <= 1'b0;
            rom_mode_reg    <= 1'b1;
        end else begin
            rom_bank_reg    <= rom_bank_next;
            ram_bank_reg    <= ram_bank_next;
            ram_enabled_reg <= ram_enabled_next;
            rom_mode_reg    <= rom_mode_next;
        end
    end

    // Advance the output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (s_tready) begin
            m_tvalid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            region_reg   <= region_next;
            mapped_reg   <= mapped_next;
            open_bus_reg <= open_bus_next;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {(MTDataW - MapW)'(0), mapped_reg};
    assign m_tuser  = {open_bus_reg, region_reg};

    // Open bus only ever marks a disabled RAM window
    a_open_bus_region: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[3] |-> m_tuser[2:0] == REGION_RAM_OFF)
        else $error("open bus outside disabled RAM");

    // A RAM bank is only held in RAM banking mode
    a_ram_bank_mode: assert property (@(posedge aclk) disable iff (!aresetn)
        ram_bank_reg != '0 |-> !rom_mode_reg)
        else $error("RAM bank set in ROM mode");

    // A banked ROM read maps through the bank held when it was taken
    a_rom_bank_map: assert property (@(posedge aclk) disable iff (!aresetn)
        s_fire && req_type == REQ_READ && address[15:14] == 2'b01
        |=> m_tvalid && m_tdata[MapW-1:14] == $past(rom_bank_reg))
        else $error("banked ROM address mismatch");

    // Banking state moves only on an accepted beat
    a_state_quiet: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_fire |=> $stable(rom_bank_reg) && $stable(ram_bank_reg)
                    && $stable(ram_enabled_reg) && $stable(rom_mode_reg))
        else $error("banking state changed without a beat");

endmodule
